[rtl/core/dtc_pkg.sv]
// Shared types and constants for the decimating trace capture block.
// Used by dtc_div, dtc_store and decimating_trace_capture; no dependencies.
package dtc_pkg;

	localparam int WORD_W    = 32;
	localparam int TICK_W    = 20;
	localparam int NUM_W     = TICK_W + 1;
	localparam int MASK_W    = 4;
	localparam int MAX_CH    = 4;
	localparam int CHSEL_W   = 2;
	localparam int OP_W      = 2;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [OP_W-1:0] {
		OP_TICK   = 2'd0,
		OP_ARM    = 2'd1,
		OP_DISARM = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MASK      = 1'd1;

	localparam logic [TICK_W-1:0] TICK_RATE_RST = 20'd30000;
	localparam logic [MASK_W-1:0] MASK_RST      = 4'hF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_WRITE,
		ST_READ,
		ST_DONE
	} state_t;

endpackage

[rtl/core/decimating_trace_capture.sv]
// Top level of the decimating trace recorder: sequencer, state and output register.
// Depends on dtc_pkg, dtc_div and dtc_store.
//
// Usage: each request on the s_axis channel carries an op in s_axis_tuser:
// tick (with four channel samples), arm (with a rate), disarm or read
// (row and channel). Every request returns exactly one result on m_axis
// holding the read word (zero except for reads), the capture flag, the
// rows stored since the last arm and the current divisor.
// Steps: a tick without a stored row, a disarm and an out-of-range read
// go from the execute step straight to the result; a valid read adds a
// registered memory read; a tick that stores a row does one memory write
// per channel; an arm with a valid rate waits for the restoring divider,
// which makes one quotient bit per cycle.
// One request is in flight at a time; s_axis_tready is high only while
// the sequencer waits for a request, and the finished result sits in the
// output register, so the next request is taken while it waits.
// When m_axis_tready is low the result holds and the sequencer waits with
// the next result until the register is free.
// Reset clears capture state, the divisor to one and the config registers
// to their defaults. The sample memory is not cleared: reads only reach
// rows below the fill count. Config writes on cfg are always taken.
module decimating_trace_capture #(
	parameter int CHANNELS = 4,
	parameter int ROWS     = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// config write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [dtc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dtc_pkg::TICK_W-1:0]         cfg_data,
	// request channel
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// low to high: sample_a, sample_b, sample_c, sample_d, rate_hz, read_row, read_channel
	input  logic [((4*32+20+$clog2(ROWS)+2+7)/8)*8-1:0] s_axis_tdata,
	// op
	input  logic [dtc_pkg::OP_W-1:0]           s_axis_tuser,
	// result channel
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// low to high: read_word, capturing, rows_filled, divider_value
	output logic [((32+1+$clog2(ROWS+1)+20+7)/8)*8-1:0] m_axis_tdata
);

	localparam int RW     = $clog2(ROWS);
	localparam int FW     = $clog2(ROWS + 1);
	localparam int CW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int AW     = RW + CW;
	localparam int WW     = dtc_pkg::WORD_W;
	localparam int TW     = dtc_pkg::TICK_W;
	localparam int OUT_W  = ((WW + 1 + FW + TW + 7) / 8) * 8;
	localparam int RATE_L = 4 * WW;
	localparam int ROW_L  = RATE_L + TW;
	localparam int CH_L   = ROW_L + RW;

	dtc_pkg::state_t state_q, state_d;

	// request payload
	dtc_pkg::op_t                           op_q;
	logic [dtc_pkg::MAX_CH-1:0][WW-1:0]     smp_q;
	logic [TW-1:0]                          rate_q;
	logic [RW-1:0]                          row_q;
	logic [dtc_pkg::CHSEL_W-1:0]            chan_q;

	logic [TW-1:0]                  tick_rate_q;
	logic [dtc_pkg::MASK_W-1:0]     mask_q;
	logic                           armed_q;
	logic [TW-1:0]                  phase_q;
	logic [TW-1:0]                  divisor_q;
	logic [FW-1:0]                  fill_q;
	logic [WW-1:0]                  word_q;
	logic [CW-1:0]                  k_q;
	logic                           m_valid_q;
	logic [OUT_W-1:0]               m_data_q;

	logic                           s_accept;
	logic [TW-1:0]                  phase_nx;
	logic [FW-1:0]                  fill_nx;
	logic                           tick_hit;
	logic                           room;
	logic                           rate_ok;
	logic                           rd_ok;
	logic                           last_ch;
	logic                           out_free;
	logic                           div_start;
	logic                           div_done;
	logic [dtc_pkg::NUM_W-1:0]      div_num;
	logic [dtc_pkg::NUM_W-1:0]      div_quo;
	logic                           mem_we;
	logic                           mem_re;
	logic [WW-1:0]                  mem_wdata;
	logic [WW-1:0]                  mem_rdata;
	logic [1:0]                     k_idx;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == dtc_pkg::ST_IDLE);
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	assign phase_nx = phase_q + TW'(1);
	assign fill_nx  = fill_q + FW'(1);
	assign tick_hit = (phase_nx >= divisor_q);
	assign room     = (fill_q < FW'(ROWS));
	assign rate_ok  = (rate_q != '0) && (rate_q <= tick_rate_q);
	assign rd_ok    = (FW'(row_q) < fill_q) && ({1'b0, chan_q} < 3'(CHANNELS));
	assign last_ch  = (k_q == CW'(CHANNELS - 1));
	assign out_free = !m_valid_q || m_axis_tready;

	assign div_num   = {1'b0, tick_rate_q} + {2'b00, rate_q[TW-1:1]};
	assign k_idx     = 2'(k_q);
	assign mem_wdata = mask_q[k_idx] ? smp_q[k_idx] : '0;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dtc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		unique case (state_q)
			dtc_pkg::ST_IDLE: begin
				if (s_accept) begin
					state_d = dtc_pkg::ST_EXEC;
				end
			end
			dtc_pkg::ST_EXEC: begin
				unique case (op_q)
					dtc_pkg::OP_TICK: begin
						state_d = (armed_q && tick_hit && room) ?
							dtc_pkg::ST_WRITE : dtc_pkg::ST_DONE;
					end
					dtc_pkg::OP_ARM: begin
						div_start = rate_ok;
						state_d   = rate_ok ? dtc_pkg::ST_DIV : dtc_pkg::ST_DONE;
					end
					dtc_pkg::OP_DISARM: begin
						state_d = dtc_pkg::ST_DONE;
					end
					dtc_pkg::OP_READ: begin
						mem_re  = rd_ok;
						state_d = rd_ok ? dtc_pkg::ST_READ : dtc_pkg::ST_DONE;
					end
					default: state_d = dtc_pkg::ST_DONE;
				endcase
			end
			dtc_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = dtc_pkg::ST_DONE;
				end
			end
			dtc_pkg::ST_WRITE: begin
				mem_we = 1'b1;
				if (last_ch) begin
					state_d = dtc_pkg::ST_DONE;
				end
			end
			dtc_pkg::ST_READ: begin
				state_d = dtc_pkg::ST_DONE;
			end
			dtc_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = dtc_pkg::ST_IDLE;
				end
			end
			default: state_d = dtc_pkg::ST_IDLE;
		endcase
	end

	// capture state, config registers and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_rate_q <= dtc_pkg::TICK_RATE_RST;
			mask_q      <= dtc_pkg::MASK_RST;
			armed_q     <= 1'b0;
			phase_q     <= '0;
			divisor_q   <= TW'(1);
			fill_q      <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					dtc_pkg::CFG_TICK_RATE: tick_rate_q <= cfg_data;
					dtc_pkg::CFG_MASK:      mask_q <= cfg_data[dtc_pkg::MASK_W-1:0];
					default: ;
				endcase
			end
			if (state_q == dtc_pkg::ST_EXEC) begin
				unique case (op_q)
					dtc_pkg::OP_TICK: begin
						if (armed_q) begin
							if (tick_hit) begin
								phase_q <= '0;
								// full buffer stops capture
								if (!room) begin
									armed_q <= 1'b0;
								end
							end else begin
								phase_q <= phase_nx;
							end
						end
					end
					dtc_pkg::OP_ARM: begin
						if (!rate_ok) begin
							divisor_q <= TW'(1);
							phase_q   <= '0;
							fill_q    <= '0;
							armed_q   <= 1'b1;
						end
					end
					dtc_pkg::OP_DISARM: armed_q <= 1'b0;
					default: ;
				endcase
			end
			if (state_q == dtc_pkg::ST_DIV && div_done) begin
				divisor_q <= div_quo[TW-1:0];
				phase_q   <= '0;
				fill_q    <= '0;
				armed_q   <= 1'b1;
			end
			if (state_q == dtc_pkg::ST_WRITE && last_ch) begin
				fill_q <= fill_nx;
				if (fill_nx >= FW'(ROWS)) begin
					armed_q <= 1'b0;
				end
			end
			if (state_q == dtc_pkg::ST_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_accept) begin
			op_q     <= dtc_pkg::op_t'(s_axis_tuser);
			smp_q[0] <= s_axis_tdata[0*WW +: WW];
			smp_q[1] <= s_axis_tdata[1*WW +: WW];
			smp_q[2] <= s_axis_tdata[2*WW +: WW];
			smp_q[3] <= s_axis_tdata[3*WW +: WW];
			rate_q   <= s_axis_tdata[RATE_L +: TW];
			row_q    <= s_axis_tdata[ROW_L +: RW];
			chan_q   <= s_axis_tdata[CH_L +: dtc_pkg::CHSEL_W];
		end
		if (state_q == dtc_pkg::ST_EXEC) begin
			k_q    <= '0;
			word_q <= '0;
		end
		if (state_q == dtc_pkg::ST_WRITE) begin
			k_q <= k_q + CW'(1);
		end
		if (state_q == dtc_pkg::ST_READ) begin
			word_q <= mem_rdata;
		end
		if (state_q == dtc_pkg::ST_DONE && out_free) begin
			m_data_q <= OUT_W'({divisor_q, fill_q, armed_q, word_q});
		end
	end

	dtc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (rate_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	dtc_store #(
		.AW (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr ({fill_q[RW-1:0], k_q}),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr ({row_q, chan_q[CW-1:0]}),
		.rdata (mem_rdata)
	);

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	a_armed_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		armed_q |-> (fill_q < FW'(ROWS)))
		else $error("capture armed with a full buffer");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		divisor_q != '0)
		else $error("divisor is zero");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == dtc_pkg::ST_DIV))
		else $error("divider finished outside the divide step");

	a_write_only_with_room: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (room && armed_q))
		else $error("row write past the end of the buffer");

endmodule

[rtl/core/dtc_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
// Depends on dtc_pkg for operand widths.
module dtc_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [dtc_pkg::NUM_W-1:0]   num,
	input  logic [dtc_pkg::TICK_W-1:0]  den,
	output logic                        done,
	output logic [dtc_pkg::NUM_W-1:0]   quo
);

	localparam int NW = dtc_pkg::NUM_W;
	localparam int DW = dtc_pkg::TICK_W;
	localparam int CNT_W = $clog2(NW + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    den_q;
	logic [NW-1:0]    quo_q;

	logic [DW:0]      rem_sh;
	logic [DW+1:0]    diff;
	logic             fits;

	assign rem_sh = {rem_q, quo_q[NW-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, den_q};
	assign fits   = !diff[DW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift the numerator out while the quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DW-1:0] : rem_sh[DW-1:0];
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

[rtl/core/dtc_store.sv]
// Sample memory: one write port, one read port with registered data.
// Depends on dtc_pkg for the word width.
module dtc_store #(
	parameter int AW = 12
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [dtc_pkg::WORD_W-1:0] wdata,
	input  logic                       re,
	input  logic [AW-1:0]              raddr,
	output logic [dtc_pkg::WORD_W-1:0] rdata
);

	logic [dtc_pkg::WORD_W-1:0] mem_q [2**AW];
	logic [dtc_pkg::WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[test/tb.sv]
// Self-checking bench for decimating_trace_capture: random-gap request driver, result monitor
// and a cycle-free software copy of the recorder that predicts every result.
// Depends on dtc_pkg and the decimating_trace_capture RTL only.
module tb;

	localparam int ROW_COUNT  = 1024;
	localparam int CH_COUNT   = 4;
	localparam int STALL_LIMIT = 5000;
	localparam logic [dtc_pkg::TICK_W-1:0] RATE_MAX = 20'hFFFFF;

	typedef struct packed {
		dtc_pkg::op_t                 op;
		logic [1:0]                   chan;
		logic [9:0]                   row;
		logic [dtc_pkg::TICK_W-1:0]   rate;
		logic [3:0][31:0]             smp;
	} trace_req_t;

	// bit layout matches m_axis_tdata, lowest field last
	typedef struct packed {
		logic [dtc_pkg::TICK_W-1:0]   div;
		logic [10:0]                  rows;
		logic                         cap;
		logic [31:0]                  word;
	} trace_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [dtc_pkg::CFG_IDX_W-1:0] cfg_index = dtc_pkg::CFG_TICK_RATE;
	logic [dtc_pkg::TICK_W-1:0]    cfg_data = '0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [159:0] s_axis_tdata = '0;
	logic [dtc_pkg::OP_W-1:0] s_axis_tuser = dtc_pkg::OP_TICK;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [63:0]  m_axis_tdata;

	decimating_trace_capture #(.CHANNELS(CH_COUNT), .ROWS(ROW_COUNT)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// recorder copy
	logic [dtc_pkg::TICK_W-1:0] tick_rate_q = dtc_pkg::TICK_RATE_RST;
	logic [dtc_pkg::MASK_W-1:0] mask_q = dtc_pkg::MASK_RST;
	logic              armed_q = 1'b0;
	logic [dtc_pkg::TICK_W-1:0] phase_q = '0;
	logic [dtc_pkg::TICK_W-1:0] divisor_q = 20'd1;
	logic [10:0]       fill_q = '0;
	logic [31:0]       trace_mem [0:ROW_COUNT-1][0:CH_COUNT-1];

	trace_req_t    pending_reqs[$];
	trace_result_t expected_results[$];
	int items_queued = 0;
	int results_seen = 0;
	int cfg_writes_taken = 0;
	int mismatches = 0;
	int idle_cycles = 0;
	logic req_accepted = 1'b0;

	task automatic record_and_predict(input trace_req_t r, output trace_result_t res);
		int unsigned t;
		int unsigned q;
		res = '0;
		case (r.op)
			dtc_pkg::OP_TICK: begin
				if (armed_q) begin
					phase_q = phase_q + 1'b1;
					if (phase_q >= divisor_q) begin
						phase_q = '0;
						if (fill_q < ROW_COUNT) begin
							for (int k = 0; k < CH_COUNT; k++)
								trace_mem[fill_q][k] = mask_q[k] ? r.smp[k] : 32'd0;
							fill_q = fill_q + 1'b1;
						end
						if (fill_q >= ROW_COUNT)
							armed_q = 1'b0;
					end
				end
			end
			dtc_pkg::OP_ARM: begin
				t = tick_rate_q;
				q = r.rate;
				if (q != 0 && q <= t)
					divisor_q = dtc_pkg::TICK_W'((t + q / 2) / q);
				else
					divisor_q = 20'd1;
				phase_q = '0;
				fill_q = '0;
				armed_q = 1'b1;
			end
			dtc_pkg::OP_DISARM: armed_q = 1'b0;
			default: begin
				// rows past the fill count read as zero
				if (r.row < fill_q)
					res.word = trace_mem[r.row][r.chan];
			end
		endcase
		res.cap = armed_q;
		res.rows = fill_q;
		res.div = divisor_q;
	endtask

	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// driver
	int req_gap = 0;
	int req_steady = 0;
	always @(negedge clk) begin
		trace_req_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (s_axis_tvalid && !req_accepted) begin
			// hold until taken
		end else if (req_gap > 0) begin
			s_axis_tvalid <= 1'b0;
			req_gap--;
		end else if (pending_reqs.size() > 0) begin
			nxt = pending_reqs.pop_front();
			s_axis_tdata <= {nxt.chan, nxt.row, nxt.rate, nxt.smp};
			s_axis_tuser <= nxt.op;
			s_axis_tvalid <= 1'b1;
			if (req_steady > 0)
				req_steady--;
			else if ($urandom_range(0, 49) == 0)
				req_steady = $urandom_range(50, 200);
			req_gap = (req_steady > 0) ? 0 : idle_span();
		end else begin
			s_axis_tvalid <= 1'b0;
		end
	end

	// result-side backpressure
	int res_stall = 0;
	int res_steady = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (res_stall > 0) begin
			m_axis_tready <= 1'b0;
			res_stall--;
		end else begin
			m_axis_tready <= 1'b1;
			if (res_steady > 0)
				res_steady--;
			else if ($urandom_range(0, 59) == 0)
				res_steady = $urandom_range(50, 200);
			else
				res_stall = idle_span();
		end
	end

	// monitor, predictor and scoreboard
	always @(posedge clk) begin
		trace_req_t    got_req;
		trace_result_t pred;
		trace_result_t act;
		trace_result_t want;
		logic          fired;
		if (arst_n) begin
			fired = 1'b0;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == dtc_pkg::CFG_TICK_RATE)
					tick_rate_q = cfg_data;
				else
					mask_q = cfg_data[dtc_pkg::MASK_W-1:0];
				cfg_writes_taken++;
				fired = 1'b1;
			end
			req_accepted <= s_axis_tvalid && s_axis_tready;
			if (s_axis_tvalid && s_axis_tready) begin
				got_req.op = dtc_pkg::op_t'(s_axis_tuser);
				{got_req.chan, got_req.row, got_req.rate, got_req.smp} = s_axis_tdata;
				record_and_predict(got_req, pred);
				expected_results.push_back(pred);
				fired = 1'b1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				act = m_axis_tdata;
				fired = 1'b1;
				results_seen++;
				if (expected_results.size() == 0) begin
					$error("result with nothing expected: %h", m_axis_tdata);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					if (act.word !== want.word) begin
						$error("read_word: expected %h, got %h", want.word, act.word);
						mismatches++;
					end
					if (act.cap !== want.cap) begin
						$error("capturing: expected %0d, got %0d", want.cap, act.cap);
						mismatches++;
					end
					if (act.rows !== want.rows) begin
						$error("rows_filled: expected %0d, got %0d", want.rows, act.rows);
						mismatches++;
					end
					if (act.div !== want.div) begin
						$error("divider_value: expected %0d, got %0d", want.div, act.div);
						mismatches++;
					end
				end
			end
			idle_cycles = fired ? 0 : idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// stimulus
	task automatic enqueue(input dtc_pkg::op_t op, input logic [dtc_pkg::TICK_W-1:0] rate,
	                       input logic [9:0] row, input logic [1:0] chan);
		trace_req_t r;
		r.op = op;
		r.rate = rate;
		r.row = row;
		r.chan = chan;
		for (int k = 0; k < 4; k++)
			r.smp[k] = $urandom;
		pending_reqs.push_back(r);
		items_queued++;
	endtask

	task automatic enqueue_tick(input logic [31:0] a, input logic [31:0] b,
	                            input logic [31:0] c, input logic [31:0] d);
		trace_req_t r;
		r = '0;
		r.op = dtc_pkg::OP_TICK;
		r.smp = {d, c, b, a};
		pending_reqs.push_back(r);
		items_queued++;
	endtask

	task automatic write_reg(input logic [dtc_pkg::CFG_IDX_W-1:0] idx,
	                         input logic [dtc_pkg::TICK_W-1:0] val);
		int seen;
		wait (results_seen >= items_queued);
		@(negedge clk);
		seen = cfg_writes_taken;
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do
			@(negedge clk);
		while (cfg_writes_taken == seen);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [dtc_pkg::TICK_W-1:0] pick_rate(input int unsigned tr);
		int r;
		int unsigned d;
		r = $urandom_range(0, 99);
		if (r < 6)
			return '0;
		if (r < 12)
			return (tr < RATE_MAX) ?
				dtc_pkg::TICK_W'($urandom_range(tr + 1, RATE_MAX)) : RATE_MAX;
		if (r < 20)
			return dtc_pkg::TICK_W'($urandom_range(0, RATE_MAX));
		// mostly small divisors so rows actually get stored
		d = $urandom_range(1, 4);
		return (tr / d == 0) ? 20'd1 : dtc_pkg::TICK_W'(tr / d);
	endfunction

	function automatic logic [9:0] pick_row();
		return ($urandom_range(0, 4) == 0) ? 10'($urandom_range(0, ROW_COUNT - 1))
		                                  : 10'($urandom_range(0, 31));
	endfunction

	task automatic run_mixed(input int n, input int unsigned tr);
		int r;
		enqueue(dtc_pkg::OP_ARM, pick_rate(tr), '0, '0);
		for (int i = 1; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 62)
				enqueue(dtc_pkg::OP_TICK, dtc_pkg::TICK_W'($urandom), 10'($urandom),
					2'($urandom));
			else if (r < 88)
				enqueue(dtc_pkg::OP_READ, dtc_pkg::TICK_W'($urandom), pick_row(),
					2'($urandom));
			else if (r < 94)
				enqueue(dtc_pkg::OP_ARM, pick_rate(tr), 10'($urandom), 2'($urandom));
			else
				enqueue(dtc_pkg::OP_DISARM, dtc_pkg::TICK_W'($urandom), 10'($urandom),
					2'($urandom));
		end
	endtask

	initial begin
		int unsigned tr;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, reset configuration
		enqueue(dtc_pkg::OP_READ, '0, '0, '0);
		enqueue_tick('1, '1, '1, '1);
		enqueue(dtc_pkg::OP_DISARM, '0, '0, '0);
		enqueue(dtc_pkg::OP_ARM, '0, '0, '0);
		enqueue_tick('1, '1, '1, '1);
		enqueue_tick('0, '0, '0, '0);
		enqueue_tick(32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0001, 32'h7FFF_FFFE);
		for (int k = 0; k < 4; k++)
			enqueue(dtc_pkg::OP_READ, '0, '0, 2'(k));
		enqueue(dtc_pkg::OP_READ, '0, 10'd2, 2'd3);
		enqueue(dtc_pkg::OP_READ, '0, 10'd3, 2'd0);
		enqueue(dtc_pkg::OP_READ, '0, 10'd1023, 2'd3);
		enqueue(dtc_pkg::OP_ARM, RATE_MAX, '0, '0);
		enqueue(dtc_pkg::OP_ARM, 20'd30000, '0, '0);
		enqueue(dtc_pkg::OP_ARM, 20'd1, '0, '0);
		enqueue_tick('1, '0, '1, '0);
		enqueue(dtc_pkg::OP_ARM, 20'd7000, '0, '0);
		for (int k = 0; k < 4; k++)
			enqueue(dtc_pkg::OP_TICK, '0, '0, '0);
		enqueue(dtc_pkg::OP_READ, '0, '0, 2'd2);
		enqueue(dtc_pkg::OP_DISARM, '0, '0, '0);
		enqueue_tick('1, '1, '1, '1);
		enqueue(dtc_pkg::OP_READ, '0, '0, 2'd1);

		write_reg(dtc_pkg::CFG_TICK_RATE, RATE_MAX);
		write_reg(dtc_pkg::CFG_MASK, 20'd0);
		run_mixed(20, RATE_MAX);

		write_reg(dtc_pkg::CFG_TICK_RATE, 20'd1);
		write_reg(dtc_pkg::CFG_MASK, 20'd5);
		run_mixed(20, 1);

		tr = $urandom_range(2, 5000);
		write_reg(dtc_pkg::CFG_TICK_RATE, dtc_pkg::TICK_W'(tr));
		write_reg(dtc_pkg::CFG_MASK, dtc_pkg::TICK_W'($urandom_range(0, 15)));
		run_mixed(20, tr);

		// fill every row so capture stops on its own, then read back and re-arm
		write_reg(dtc_pkg::CFG_TICK_RATE, 20'd100);
		write_reg(dtc_pkg::CFG_MASK, 20'd15);
		enqueue(dtc_pkg::OP_ARM, 20'd100, '0, '0);
		for (int i = 0; i < ROW_COUNT + 2; i++) begin
			enqueue(dtc_pkg::OP_TICK, '0, '0, '0);
			if ($urandom_range(0, 99) == 0)
				enqueue(dtc_pkg::OP_READ, '0, 10'($urandom_range(0, i)), 2'($urandom));
		end
		for (int i = 0; i < 4; i++)
			enqueue(dtc_pkg::OP_READ, '0, 10'($urandom), 2'($urandom));
		enqueue(dtc_pkg::OP_ARM, 20'd50, '0, '0);
		for (int i = 0; i < 4; i++)
			enqueue(dtc_pkg::OP_TICK, '0, '0, '0);
		for (int i = 0; i < 3; i++)
			enqueue(dtc_pkg::OP_READ, '0, 10'($urandom_range(0, 3)), 2'($urandom));

		write_reg(dtc_pkg::CFG_TICK_RATE, 20'd30000);
		write_reg(dtc_pkg::CFG_MASK, 20'd9);
		run_mixed(20, 30000);

		wait (results_seen >= items_queued);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
